FILE: design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and the UTF-8 sequence decoder for the transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [15:0] REPL_CHAR     = 16'hfffd;
    localparam logic [20:0] CP_TWO_MIN    = 21'h000080;
    localparam logic [20:0] CP_THREE_MIN  = 21'h000800;
    localparam logic [20:0] CP_SURR_LO    = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00dfff;
    localparam logic [20:0] CP_SUPP_MIN   = 21'h010000;
    localparam logic [20:0] CP_MAX        = 21'h10ffff;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hd800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hdc00;
    localparam int          MAX_RESULTS   = 4;

    // One result beat
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        text_end;
    } result_t;

    // All results caused by one input byte
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [2:0]                count;
    } bundle_t;

    // Decoded head sequence: code point and bytes consumed
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  len;
    } decode_t;

    // Decode the sequence that starts at b0; absent bytes are zero
    function automatic decode_t decode_head(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
        logic [20:0] v2;
        logic [20:0] v3;
        logic [20:0] v4;
        decode_t     d;
        v2 = {10'd0, b0[4:0], b1[5:0]};
        v3 = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        v4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        d.cp  = {5'd0, REPL_CHAR};
        d.len = 3'd1;
        if (b0[7] == 1'b0)
        begin
            d.cp = {13'd0, b0};
        end
        else if (b0[7:5] == 3'b110 && b1 != 8'd0)
        begin
            if (v2 >= CP_TWO_MIN)
            begin
                d.cp  = v2;
                d.len = 3'd2;
            end
        end
        else if (b0[7:4] == 4'b1110 && b1 != 8'd0 && b2 != 8'd0)
        begin
            if (v3 >= CP_THREE_MIN && !(v3 >= CP_SURR_LO && v3 <= CP_SURR_HI))
            begin
                d.cp  = v3;
                d.len = 3'd3;
            end
        end
        else if (b0[7:3] == 5'b11110 && b1 != 8'd0 && b2 != 8'd0 && b3 != 8'd0)
        begin
            if (v4 >= CP_SUPP_MIN && v4 <= CP_MAX)
            begin
                d.cp  = v4;
                d.len = 3'd4;
            end
        end
        return d;
    endfunction

endpackage

FILE: design/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Input register, pending-byte window and single-pass decode of one byte
// into a bundle of up to four results.
// ----------------------------------------------------------------------------
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] in_byte
    output logic        load_valid,
    output bundle_t     load_bundle,
    input  logic        load_ready
);

    logic            in_valid_reg;
    logic            in_valid_next;
    logic [7:0]      in_byte_reg;
    logic [2:0][7:0] pend_reg;
    logic [2:0][7:0] pend_next;
    logic [1:0]      pend_cnt_reg;
    logic [1:0]      pend_cnt_next;
    logic            fire;
    logic [3:0][7:0] win;
    decode_t         d_full;
    decode_t [2:0]   d_drain;
    logic [19:0]     cp_off;

    assign fire       = in_valid_reg && load_ready;
    assign s_tready   = !in_valid_reg || fire;
    assign load_valid = in_valid_reg;

    // Decode candidates: full window, and each drain offset
    assign win        = {in_byte_reg, pend_reg[2], pend_reg[1], pend_reg[0]};
    assign d_full     = decode_head(pend_reg[0], pend_reg[1], pend_reg[2], in_byte_reg);
    assign d_drain[0] = decode_head(pend_reg[0], pend_reg[1], pend_reg[2], 8'd0);
    assign d_drain[1] = decode_head(pend_reg[1], pend_reg[2], 8'd0, 8'd0);
    assign d_drain[2] = decode_head(pend_reg[2], 8'd0, 8'd0, 8'd0);
    assign cp_off     = 20'(d_full.cp - CP_SUPP_MIN);

    // Work out the results and the next window
    always_comb
    begin
        logic [2:0] pos;
        logic [2:0] k;
        logic [2:0] src;
        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        load_bundle   = '0;
        pos           = 3'd0;
        k             = 3'd0;
        src           = 3'd0;
        if (in_byte_reg != 8'd0)
        begin
            if (pend_cnt_reg != 2'd3)
            begin
                // Window still filling: hold the byte, no result
                pend_next[pend_cnt_reg] = in_byte_reg;
                pend_cnt_next           = pend_cnt_reg + 2'd1;
            end
            else
            begin
                if (d_full.cp[20:16] != 5'd0)
                begin
                    load_bundle.res[0] = '{HIGH_SURR_BASE + {6'd0, cp_off[19:10]}, 1'b1, 1'b0};
                    load_bundle.res[1] = '{LOW_SURR_BASE + {6'd0, cp_off[9:0]}, 1'b1, 1'b0};
                    load_bundle.count  = 3'd2;
                end
                else
                begin
                    load_bundle.res[0] = '{d_full.cp[15:0], 1'b1, 1'b0};
                    load_bundle.count  = 3'd1;
                end
                // Drop the consumed bytes, keep the rest in order
                for (int i = 0; i < 3; i++)
                begin
                    src = d_full.len + 3'(i);
                    pend_next[i] = (src < 3'd4) ? win[src[1:0]] : 8'd0;
                end
                pend_cnt_next = 2'(3'd4 - d_full.len);
            end
        end
        else
        begin
            // Terminator: drain the window, then the end marker
            for (int s = 0; s < 3; s++)
            begin
                if (pos < {1'b0, pend_cnt_reg})
                begin
                    load_bundle.res[k[1:0]] = '{d_drain[pos[1:0]].cp[15:0], 1'b1, 1'b0};
                    k   = k + 3'd1;
                    pos = pos + d_drain[pos[1:0]].len;
                end
            end
            load_bundle.res[k[1:0]] = '{16'd0, 1'b0, 1'b1};
            load_bundle.count       = k + 3'd1;
            pend_next               = '0;
            pend_cnt_next           = 2'd0;
        end
    end

    // Input register valid
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= '0;
            pend_cnt_reg <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                pend_reg     <= pend_next;
                pend_cnt_reg <= pend_cnt_next;
            end
        end
    end

    // Capture the incoming beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

endmodule

FILE: design/u8u16_out.sv
// ----------------------------------------------------------------------------
// u8u16_out
// Result register: holds one bundle and sends its results one beat at a time.
// ----------------------------------------------------------------------------
module u8u16_out
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_valid,
    input  bundle_t     load_bundle,
    output logic        load_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [15:0] code_unit
    output logic [0:0]  m_tuser,      // [0] unit_valid
    output logic        m_tlast       // text_end
);

    result_t [MAX_RESULTS-1:0] res_reg;
    logic [2:0]                cnt_reg;
    logic [2:0]                cnt_next;
    logic [1:0]                idx_reg;
    logic [1:0]                idx_next;
    logic                      beat;
    logic                      last_beat;
    logic                      load;
    result_t                   cur;

    assign cur        = res_reg[idx_reg];
    assign m_tvalid   = cnt_reg != 3'd0;
    assign m_tdata    = cur.code_unit;
    assign m_tuser[0] = cur.unit_valid;
    assign m_tlast    = cur.text_end;

    assign beat       = m_tvalid && m_tready;
    assign last_beat  = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign load_ready = !m_tvalid || (beat && last_beat);
    assign load       = load_valid && load_ready;

    // Advance through the bundle, reload after its last beat
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = load_bundle.count;
            idx_next = 2'd0;
        end
        else if (beat)
        begin
            if (last_beat)
            begin
                cnt_next = 3'd0;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Hold the bundle payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_bundle.res;
        end
    end

endmodule

FILE: design/utf8_to_utf16_transcoder.sv
// Path: a byte is held in the input register, then its results in the result
//   register.
// Throughput: one byte per cycle unless the output stalls; a surrogate pair
//   takes two output beats and a zero byte up to four (pending units plus end
//   marker), as the result register sends one beat per cycle under m_tready.
// Reset: asynchronous, clears the pending-byte window and all valid flags.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streams UTF-8 bytes in and UTF-16 code units out, with an end marker after
// the terminating zero byte.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // [15:0] code_unit
    output logic [0:0]  m_tuser,      // [0] unit_valid
    output logic        m_tlast       // text_end
);

    logic    load_valid;
    logic    load_ready;
    bundle_t load_bundle;

    // Decode stage
    u8u16_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .load_valid  (load_valid),
        .load_bundle (load_bundle),
        .load_ready  (load_ready)
    );

    // Result register and beat sequencing
    u8u16_out u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (load_valid),
        .load_bundle (load_bundle),
        .load_ready  (load_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - UTF-8 to UTF-16 transcoder testbench
// Drives UTF-8 byte beats into the transcoder and checks every UTF-16 code
// unit and end marker against a code-unit predictor held in a scoreboard.
// A directed set of characters and faulty sequences comes first, then about
// four hundred bytes of random text that is mostly well formed.
// ----------------------------------------------------------------------------
module tb
    import u8u16_pkg::*;
;

    // Scoreboard: predicts the code units of each accepted byte and checks
    // the result beats against them in order
    class utf16_scoreboard;
        result_t         units_due[$];
        logic [2:0][7:0] window;
        int unsigned     fill;
        int unsigned     faults;

        function new();
            window = '0;
            fill   = 0;
            faults = 0;
        endfunction

        // Append one predicted unit at the tail
        function void queue_unit(input result_t r);
            units_due.insert(units_due.size(), r);
        endfunction

        // Decode the sequence that starts at w[0]; absent bytes read as zero
        function void decode_seq(input logic [3:0][7:0] w, output logic [20:0] cp,
                                 output int unsigned used);
            logic [20:0] v2;
            logic [20:0] v3;
            logic [20:0] v4;
            v2   = {10'd0, w[0][4:0], w[1][5:0]};
            v3   = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
            v4   = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
            cp   = {5'd0, REPL_CHAR};
            used = 1;
            if (!w[0][7])
            begin
                cp = {13'd0, w[0]};
            end
            else if (w[0][7:5] == 3'b110)
            begin
                if (w[1] != 8'd0 && v2 >= CP_TWO_MIN)
                begin
                    cp   = v2;
                    used = 2;
                end
            end
            else if (w[0][7:4] == 4'b1110)
            begin
                // Reject overlong forms and surrogate values
                if (w[1] != 8'd0 && w[2] != 8'd0 && v3 >= CP_THREE_MIN &&
                    !(v3 >= CP_SURR_LO && v3 <= CP_SURR_HI))
                begin
                    cp   = v3;
                    used = 3;
                end
            end
            else if (w[0][7:3] == 5'b11110)
            begin
                if (w[1] != 8'd0 && w[2] != 8'd0 && w[3] != 8'd0 &&
                    v4 >= CP_SUPP_MIN && v4 <= CP_MAX)
                begin
                    cp   = v4;
                    used = 4;
                end
            end
        endfunction

        // Queue one code unit, or a surrogate pair high half first
        function int unsigned emit(input logic [20:0] cp);
            logic [20:0] off;
            result_t     r;
            r.unit_valid = 1'b1;
            r.text_end   = 1'b0;
            if (cp <= 21'h00ffff)
            begin
                r.code_unit = cp[15:0];
                queue_unit(r);
                return 1;
            end
            off = cp - CP_SUPP_MIN;
            r.code_unit = HIGH_SURR_BASE + {6'd0, off[19:10]};
            queue_unit(r);
            r.code_unit = LOW_SURR_BASE + {6'd0, off[9:0]};
            queue_unit(r);
            return 2;
        endfunction

        // Decode the head, emit its units and keep the bytes not consumed
        function int unsigned consume(input logic [3:0][7:0] w, input int unsigned avail);
            logic [20:0] cp;
            int unsigned used;
            int unsigned rest;
            int unsigned made;
            decode_seq(w, cp, used);
            made = emit(cp);
            if (used > avail)
                used = avail;
            rest = avail - used;
            if (rest > 3)
                rest = 3;
            window = '0;
            for (int i = 0; i < rest; i++)
                window[i] = w[(used + i) & 3];
            fill = rest;
            return made;
        endfunction

        // Note an accepted byte beat
        function void note_byte(input logic [7:0] b);
            logic [3:0][7:0] w;
            int unsigned     made;
            result_t         marker;
            made = 0;
            if (b != 8'd0)
            begin
                // Hold the byte until a fourth one arrives
                if (fill < 3)
                begin
                    window[fill] = b;
                    fill++;
                    return;
                end
                w    = {b, window[2], window[1], window[0]};
                made = consume(w, 4);
                return;
            end
            // Zero byte: drain the window, then close the text
            while (fill > 0 && made < 3)
            begin
                w = '0;
                for (int i = 0; i < fill; i++)
                    w[i] = window[i];
                made += consume(w, fill);
            end
            window = '0;
            fill   = 0;
            marker.code_unit  = 16'd0;
            marker.unit_valid = 1'b0;
            marker.text_end   = 1'b1;
            queue_unit(marker);
        endfunction

        // Check a result beat against the oldest predicted unit
        function void check_unit(input logic [15:0] unit, input logic valid, input logic last);
            result_t want;
            if (units_due.size() == 0)
            begin
                if (faults < 10)
                    $display("unexpected result beat: unit %h valid %b end %b",
                             unit, valid, last);
                faults++;
                return;
            end
            want = units_due.pop_front();
            if (want.code_unit !== unit || want.unit_valid !== valid ||
                want.text_end !== last)
            begin
                if (faults < 10)
                    $display({"wrong result: expected unit %h valid %b end %b, ",
                              "got unit %h valid %b end %b"},
                             want.code_unit, want.unit_valid, want.text_end,
                             unit, valid, last);
                faults++;
            end
        endfunction

        function int unsigned outstanding();
            return units_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    utf16_scoreboard sb;
    logic [7:0]      text_bytes[$];
    bit              rx_holding;
    int unsigned     rx_count;

    utf8_to_utf16_transcoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Append one byte to the text
    function automatic void add_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    // Continuation byte; now and then with random top bits, which pass unchecked
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        logic [7:0] c;
        c = {2'b10, bits};
        if ($urandom_range(0, 9) == 0)
            c = {2'($urandom_range(0, 3)), bits};
        if (c == 8'd0)
            c = 8'h40;
        return c;
    endfunction

    // Append one random sequence to the text
    task automatic append_random_sequence();
        int unsigned pick;
        int unsigned cp;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            add_byte(8'd0);
        end
        else if (pick < 26)
        begin
            add_byte(8'($urandom_range(1, 127)));
        end
        else if (pick < 44)
        begin
            cp = $urandom_range(32'h80, 32'h7ff);
            add_byte({3'b110, cp[10:6]});
            add_byte(cont_byte(cp[5:0]));
        end
        else if (pick < 62)
        begin
            // Surrogate values fall in now and then
            cp = $urandom_range(32'h800, 32'hffff);
            add_byte({4'b1110, cp[15:12]});
            add_byte(cont_byte(cp[11:6]));
            add_byte(cont_byte(cp[5:0]));
        end
        else if (pick < 78)
        begin
            cp = $urandom_range(32'h10000, 32'h10ffff);
            add_byte({5'b11110, cp[20:18]});
            add_byte(cont_byte(cp[17:12]));
            add_byte(cont_byte(cp[11:6]));
            add_byte(cont_byte(cp[5:0]));
        end
        else if (pick < 86)
        begin
            // Lead with up to two continuation bytes: truncated for the longer leads
            case ($urandom_range(0, 2))
                0:       add_byte({3'b110, 5'($urandom_range(0, 31))});
                1:       add_byte({4'b1110, 4'($urandom_range(0, 15))});
                default: add_byte({5'b11110, 3'($urandom_range(0, 7))});
            endcase
            n = $urandom_range(0, 2);
            repeat (n)
                add_byte(cont_byte(6'($urandom_range(0, 63))));
            if ($urandom_range(0, 1) == 1)
                add_byte(8'd0);
        end
        else if (pick < 92)
        begin
            // Overlong two-byte forms, or four-byte forms that may run out of range
            if ($urandom_range(0, 1) == 1)
            begin
                add_byte({7'b1100000, 1'($urandom_range(0, 1))});
                add_byte(cont_byte(6'($urandom_range(0, 63))));
            end
            else
            begin
                add_byte({5'b11110, 3'($urandom_range(0, 7))});
                repeat (3)
                    add_byte(cont_byte(6'($urandom_range(0, 63))));
            end
        end
        else
        begin
            add_byte(8'($urandom_range(1, 255)));
        end
    endtask

    // Offer one byte beat after an idle gap and wait for its acceptance
    task automatic send_byte(input logic [7:0] b, input int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
    endtask

    // Stimulus and end of run
    initial
    begin
        logic [7:0]  directed[$];
        int unsigned idx;
        int unsigned gap;
        directed = {8'h01, 8'h7f, 8'hc3, 8'ha9, 8'hc0, 8'h80,
                    8'he2, 8'h82, 8'hac, 8'hed, 8'ha0, 8'h80,
                    8'hf0, 8'h9f, 8'h98, 8'h80, 8'hf4, 8'h90, 8'h80, 8'h80,
                    8'h80, 8'hff, 8'he2, 8'h82, 8'h00, 8'h00};
        sb         = new();
        rx_holding = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        m_tready   = 1'b0;
        while (text_bytes.size() < 400)
            append_random_sequence();
        add_byte(8'd0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed characters and faulty sequences
        foreach (directed[i])
            send_byte(directed[i], $urandom_range(0, 3));

        // Random text; stretches without gaps and during the receiver hold-off
        idx = 0;
        foreach (text_bytes[i])
        begin
            if (rx_holding || (idx / 50) % 4 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            send_byte(text_bytes[i], gap);
            idx++;
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain, then allow for stray beats
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.faults == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off to fill the block
    initial
    begin
        int unsigned gap;
        bit          held;
        held     = 1'b0;
        rx_count = 0;
        @(posedge rst_n);
        forever
        begin
            if (!held && rx_count == 60)
            begin
                held       = 1'b1;
                rx_holding = 1'b1;
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (299) @(negedge clk);
                rx_holding = 1'b0;
            end
            if ((rx_count / 40) % 4 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_unit(m_tdata, m_tuser[0], m_tlast);
            rx_count++;
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
